@@ design/assert_macros.svh @@
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden state");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ design/dir_pkg.sv @@
package dir_pkg;
  localparam int unsigned MagW = 96;
  localparam int unsigned MaxScale = 28;
  localparam int unsigned DigW = 4;

  typedef enum logic [1:0] {
    CmdFloor = 2'd0,
    CmdRound = 2'd1,
    CmdTrunc = 2'd2,
    CmdNeg   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StInc,
    StDone
  } state_e;

  // per-pass control from sequencer to divider
  typedef struct packed {
    logic load;
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

@@ design/dir_div10.sv @@
// bit-serial divide by ten of a 96-bit magnitude, msb first, one bit a cycle
module dir_div10 import dir_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_ctrl_t       ctrl_i,
  input  logic [MagW-1:0] load_val_i,
  output div_stat_t       stat_o,
  output logic [MagW-1:0] quot_o,
  output logic [DigW-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [MagW-1:0] sh_q, sh_d;
  logic [DigW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DigW:0]   trial;

  assign trial = {rem_q, sh_q[MagW-1]};

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (ctrl_i.load) begin
      sh_d = load_val_i;
    end
    if (ctrl_i.start) begin
      rem_d  = '0;
      cnt_d  = CntW'(MagW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= (DigW+1)'(10)) begin
        rem_d = DigW'(trial - (DigW+1)'(10));
        sh_d  = {sh_q[MagW-2:0], 1'b1};
      end else begin
        rem_d = trial[DigW-1:0];
        sh_d  = {sh_q[MagW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = sh_q;
  assign rem_o  = rem_q;
endmodule

@@ design/decimal_integer_rounding.sv @@
// channel | signals                                              | dir
// in      | in_valid_i, in_stall_o, command_i, mant_*_i, ...      | in
// out     | out_valid_o, out_stall_i, res_*_o, status_o           | out
// one request at a time; floor/round/truncate run one bit-serial divide-by-ten pass
// per scale digit, then the increment when it is needed; the increment adds the
// carry across the magnitude in 32-bit slices, low slice first
// negate, bad scale and scale 0 skip the divide and go from idle straight to done
// reset is asynchronous, active low; a result waits in the output register
// while out_stall_i is high, and in_stall_o stays high until it is taken
`include "assert_macros.svh"
module decimal_integer_rounding import dir_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] mant_low_i,
  input  logic [31:0] mant_mid_i,
  input  logic [31:0] mant_high_i,
  input  logic        negative_i,
  input  logic [7:0]  scale_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] res_low_o,
  output logic [31:0] res_mid_o,
  output logic [31:0] res_high_o,
  output logic        res_negative_o,
  output logic [7:0]  res_scale_o,
  output logic        status_o
);
  state_e          st_q, st_d;
  cmd_e            cmd_q;
  logic            neg_q;
  logic [7:0]      scale_q;
  logic [4:0]      left_q, left_d;
  logic            sticky_q, sticky_d;
  logic [DigW-1:0] last_q, last_d;
  logic [MagW-1:0] mag_q, mag_d;
  logic [1:0]      slice_q, slice_d;
  logic            carry_q, carry_d;
  logic            ovf_q, ovf_d;
  logic            accept, take;
  logic            ov_q;
  logic [31:0]     rl_q, rm_q, rh_q;
  logic            rn_q, rs_q;
  logic [7:0]      rsc_q;
  logic            fin;
  logic            up;
  logic            inc;
  div_ctrl_t       dctrl;
  div_stat_t       dstat;
  logic [MagW-1:0] quot;
  logic [DigW-1:0] rem;
  logic [32:0]     slice_sum;

  assign accept     = in_valid_i && !in_stall_o;
  assign take       = ov_q && !out_stall_i;
  assign in_stall_o = (st_q != StIdle) || ov_q;

  dir_div10 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dctrl),
    .load_val_i (mag_d),
    .stat_o     (dstat),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    up = 1'b0;
    case (cmd_q)
      CmdFloor: up = neg_q && (sticky_q || (last_q != '0));
      CmdRound: up = (last_q > DigW'(5)) ||
                     ((last_q == DigW'(5)) && (sticky_q || mag_q[0]));
      default:  up = 1'b0;
    endcase
  end

  // decision is taken on the first slice, before the lsb changes
  assign inc = up || (slice_q != 2'd0);

  always_comb begin
    case (slice_q)
      2'd0:    slice_sum = {1'b0, mag_q[31:0]} + 33'(carry_q);
      2'd1:    slice_sum = {1'b0, mag_q[63:32]} + 33'(carry_q);
      default: slice_sum = {1'b0, mag_q[95:64]} + 33'(carry_q);
    endcase
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (accept) begin
          if (command_i == CmdNeg || scale_in_i > 8'(MaxScale) || scale_in_i == '0) begin
            st_d = StDone;
          end else begin
            st_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (dstat.done && left_q == 5'd1) st_d = StInc;
      end
      StInc: begin
        if (!inc || slice_q == 2'd2) st_d = StDone;
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mag_d    = mag_q;
    left_d   = left_q;
    sticky_d = sticky_q;
    last_d   = last_q;
    slice_d  = slice_q;
    carry_d  = carry_q;
    ovf_d    = ovf_q;
    dctrl    = '{load: 1'b0, start: 1'b0};
    fin      = (st_q == StDone);
    case (st_q)
      StIdle: begin
        if (accept) begin
          mag_d    = {mant_high_i, mant_mid_i, mant_low_i};
          left_d   = scale_in_i[4:0];
          sticky_d = 1'b0;
          last_d   = '0;
          slice_d  = '0;
          carry_d  = 1'b1;
          ovf_d    = 1'b0;
          if (command_i != CmdNeg && scale_in_i <= 8'(MaxScale) && scale_in_i != '0) begin
            dctrl.load  = 1'b1;
            dctrl.start = 1'b1;
          end
        end
      end
      StDiv: begin
        if (dstat.done) begin
          mag_d  = quot;
          left_d = left_q - 1'b1;
          if (left_q == 5'd1) begin
            last_d = rem;
          end else begin
            if (rem != '0) sticky_d = 1'b1;
            dctrl.start = 1'b1;
          end
        end
      end
      StInc: begin
        if (inc) begin
          case (slice_q)
            2'd0:    mag_d[31:0]  = slice_sum[31:0];
            2'd1:    mag_d[63:32] = slice_sum[31:0];
            default: mag_d[95:64] = slice_sum[31:0];
          endcase
          carry_d = slice_sum[32];
          slice_d = slice_q + 1'b1;
          if (slice_q == 2'd2) ovf_d = slice_sum[32];
        end
      end
      default: ;
    endcase
    // divider takes the updated quotient on the next pass
    if (st_q == StDiv && dstat.done && left_q != 5'd1) dctrl.load = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (fin) ov_q <= 1'b1;
      else if (take) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    left_q   <= left_d;
    sticky_q <= sticky_d;
    last_q   <= last_d;
    slice_q  <= slice_d;
    carry_q  <= carry_d;
    ovf_q    <= ovf_d;
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      neg_q   <= negative_i;
      scale_q <= scale_in_i;
    end
    if (fin) begin
      if (cmd_q == CmdNeg) begin
        rs_q <= 1'b0;
        {rh_q, rm_q, rl_q} <= mag_q;
        if (mag_q == '0) begin
          rn_q  <= 1'b0;
          rsc_q <= '0;
        end else begin
          rn_q  <= !neg_q;
          rsc_q <= scale_q;
        end
      end else if (scale_q > 8'(MaxScale) || ovf_q) begin
        rs_q <= 1'b1;
        {rh_q, rm_q, rl_q} <= '0;
        rn_q  <= 1'b0;
        rsc_q <= '0;
      end else begin
        rs_q <= 1'b0;
        {rh_q, rm_q, rl_q} <= mag_q;
        rn_q  <= neg_q;
        rsc_q <= '0;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign res_low_o      = rl_q;
  assign res_mid_o      = rm_q;
  assign res_high_o     = rh_q;
  assign res_negative_o = rn_q;
  assign res_scale_o    = rsc_q;
  assign status_o       = rs_q;

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, (st_q != StIdle) |-> !accept)
  `ASSERT_IMPL(a_err_zero, clk_i, rst_ni, (ov_q && rs_q) |-> ({rh_q, rm_q, rl_q} == '0 && !rn_q))
  `ASSERT_NEVER(a_div_outside, clk_i, rst_ni, dstat.busy && st_q != StDiv)
  `ASSERT_IMPL(a_hold, clk_i, rst_ni, (ov_q && out_stall_i) |=> (ov_q && $stable(rl_q)))
endmodule
